// ===== rtl/rle8sd_pkg.sv =====
`timescale 1ns / 1ps

package rle8sd_pkg;

   // operation codes carried in tuser bit 0
   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_PIXEL   = 1'b1;

   // header layout
   localparam logic [3:0] HEADER_BYTES  = 4'd8;
   localparam logic [3:0] HDR_WIDTH_LO  = 4'd0;
   localparam logic [3:0] HDR_WIDTH_HI  = 4'd1;
   localparam logic [3:0] HDR_HEIGHT_LO = 4'd2;
   localparam logic [3:0] HDR_HEIGHT_HI = 4'd3;

   localparam logic [23:0] MIN_FRAME_BYTES = 24'd8;

   // run decoder: expecting skip count, expecting draw count, above: pixels left + 2
   localparam logic [8:0] RUN_SKIP = 9'd2;
   localparam logic [8:0] RUN_DRAW = 9'd1;

   typedef struct packed {
      logic        emit;
      logic [7:0]  index;
      logic [14:0] x;
      logic [14:0] y;
   } pix_req_type;

   typedef struct packed {
      logic        write;
      logic [7:0]  index;
      logic [23:0] color;
   } pal_wr_type;

endpackage

// ===== rtl/rle8sd_pixel_pipe.sv =====
`timescale 1ns / 1ps

module rle8sd_pixel_pipe #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rle8sd_pkg::pal_wr_type   pal_wr,
   input  rle8sd_pkg::pix_req_type  pix_req,
   output logic                     in_ready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pixel_x[14:0], pixel_y[29:15], red[37:30], green[45:38], blue[53:46], zero pad
   output logic [55:0]              rsp_tdata
);
   import rle8sd_pkg::*;

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [8:0] NUM_ENTRIES = 9'(PALETTE_ENTRIES);

   logic [23:0] palette_mem [PALETTE_ENTRIES];

   logic        wr_in_range;
   logic        rd_in_range;
   logic        s1_advance;

   logic        s1_valid_ff;
   logic        s1_in_range_ff;
   logic [14:0] s1_x_ff;
   logic [14:0] s1_y_ff;
   logic [23:0] rd_data_ff;

   logic        out_valid_ff;
   logic [14:0] out_x_ff;
   logic [14:0] out_y_ff;
   logic [23:0] out_color_ff;

   assign wr_in_range = {1'b0, pal_wr.index} < NUM_ENTRIES;
   assign rd_in_range = {1'b0, pix_req.index} < NUM_ENTRIES;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign in_ready   = !s1_valid_ff || !out_valid_ff || rsp_tready;

   // palette: one write or one read per transfer
   always_ff @(posedge clock) begin
      if (pal_wr.write && wr_in_range) begin
         palette_mem[pal_wr.index[AW-1:0]] <= pal_wr.color;
      end
      if (pix_req.emit && rd_in_range) begin
         rd_data_ff <= palette_mem[pix_req.index[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pix_req.emit) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_req.emit) begin
         s1_x_ff        <= pix_req.x;
         s1_y_ff        <= pix_req.y;
         s1_in_range_ff <= rd_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // out-of-range index reads as black
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_x_ff     <= s1_x_ff;
         out_y_ff     <= s1_y_ff;
         out_color_ff <= s1_in_range_ff ? rd_data_ff : 24'd0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_color_ff[7:0], out_color_ff[15:8], out_color_ff[23:16],
                        out_y_ff, out_x_ff};

endmodule

// ===== rtl/rle8_sprite_decoder.sv =====
`timescale 1ns / 1ps
// Path: a drawn pixel reaches rsp through the palette read register, then
//   the output register.
// Throughput: one byte or palette write per cycle while rsp is not held off;
//   once back-pressure on rsp fills the pipeline, req_tready drops.
// Reset: synchronous, active high; clears the decoder to idle and empties the
//   pipeline. Palette contents are undefined until written.

module rle8_sprite_decoder #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_byte[7:0], frame_bytes[31:8], palette_index[39:32],
   // red_in[47:40], green_in[55:48], blue_in[63:56]
   input  logic [63:0] req_tdata,
   // op[0], first_byte[1]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_x[14:0], pixel_y[29:15], red_out[37:30], green_out[45:38],
   // blue_out[53:46], zero pad[55:54]
   output logic [55:0] rsp_tdata
);
   import rle8sd_pkg::*;

   logic        accept;
   logic        op;
   logic        first;
   logic [7:0]  data_b;
   logic [23:0] fbytes;

   // decoder state
   logic [3:0]  hdr_count_ff,  hdr_count_in;
   logic [7:0]  hdr_low_ff,    hdr_low_in;
   logic [15:0] width_ff,      width_in;
   logic [15:0] height_ff,     height_in;
   logic [15:0] row_ff,        row_in;
   logic [16:0] column_ff,     column_in;
   logic [8:0]  run_ff,        run_in;
   logic [7:0]  line_left_ff,  line_left_in;
   logic        line_valid_ff, line_valid_in;
   logic [23:0] bytes_left_ff, bytes_left_in;
   logic        active_ff,     active_in;

   logic        emit;
   pix_req_type pix_req;
   pal_wr_type  pal_wr;

   assign accept = req_tvalid && req_tready;
   assign op     = req_tuser[0];
   assign first  = req_tuser[1];
   assign data_b = req_tdata[7:0];
   assign fbytes = req_tdata[31:8];

   // Walk one picture byte through header, line length and run parsing.
   always_comb begin
      hdr_count_in  = hdr_count_ff;
      hdr_low_in    = hdr_low_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      row_in        = row_ff;
      column_in     = column_ff;
      run_in        = run_ff;
      line_left_in  = line_left_ff;
      line_valid_in = line_valid_ff;
      bytes_left_in = bytes_left_ff;
      active_in     = active_ff;
      emit          = 1'b0;

      if (accept && op == OP_PIXEL) begin
         // a new picture abandons whatever was in flight
         if (first) begin
            active_in     = fbytes >= MIN_FRAME_BYTES;
            bytes_left_in = fbytes;
            hdr_count_in  = 4'd0;
            hdr_low_in    = 8'd0;
            row_in        = 16'd0;
            column_in     = 17'd0;
            run_in        = RUN_SKIP;
            line_left_in  = 8'd0;
            line_valid_in = 1'b0;
         end

         if (!active_in || bytes_left_in == 24'd0) begin
            active_in = 1'b0;
         end else begin
            bytes_left_in = bytes_left_in - 24'd1;

            if (hdr_count_in < HEADER_BYTES) begin
               case (hdr_count_in) inside
                  HDR_WIDTH_LO, HDR_HEIGHT_LO: hdr_low_in = data_b;
                  HDR_WIDTH_HI:                width_in   = {data_b, hdr_low_in};
                  HDR_HEIGHT_HI:               height_in  = {data_b, hdr_low_in};
                  default: ;  // offset words are dropped
               endcase
               hdr_count_in = hdr_count_in + 4'd1;
               if (hdr_count_in == HEADER_BYTES) begin
                  // non-positive width or height ends the picture
                  if (width_in == 16'd0 || width_in[15] ||
                      height_in == 16'd0 || height_in[15]) begin
                     active_in = 1'b0;
                  end
                  row_in        = 16'd0;
                  line_valid_in = 1'b0;
               end
            end else if (!line_valid_in) begin
               if (data_b == 8'd0) begin
                  // empty line: finish the row at once
                  line_valid_in = 1'b0;
                  row_in        = row_in + 16'd1;
                  if (row_in >= height_in) begin
                     active_in = 1'b0;
                  end
               end else if (bytes_left_in < {16'd0, data_b}) begin
                  // line overruns the picture: stop
                  active_in = 1'b0;
               end else begin
                  line_valid_in = 1'b1;
                  line_left_in  = data_b;
                  run_in        = RUN_SKIP;
                  column_in     = 17'd0;
               end
            end else begin
               if (run_in == RUN_SKIP) begin
                  column_in = column_in + {9'd0, data_b};
                  run_in    = RUN_DRAW;
               end else if (run_in == RUN_DRAW) begin
                  run_in = RUN_SKIP + {1'b0, data_b};
               end else begin
                  // pixels beyond the width are consumed silently
                  emit      = column_in < {1'b0, width_in};
                  column_in = column_in + 17'd1;
                  run_in    = run_in - 9'd1;
               end
               line_left_in = line_left_in - 8'd1;
               if (line_left_in == 8'd0) begin
                  line_valid_in = 1'b0;
                  row_in        = row_in + 16'd1;
                  if (row_in >= height_in) begin
                     active_in = 1'b0;
                  end
               end
            end

            if (bytes_left_in == 24'd0) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_count_ff  <= 4'd0;
         hdr_low_ff    <= 8'd0;
         width_ff      <= 16'd0;
         height_ff     <= 16'd0;
         row_ff        <= 16'd0;
         column_ff     <= 17'd0;
         run_ff        <= RUN_SKIP;
         line_left_ff  <= 8'd0;
         line_valid_ff <= 1'b0;
         bytes_left_ff <= 24'd0;
         active_ff     <= 1'b0;
      end else begin
         hdr_count_ff  <= hdr_count_in;
         hdr_low_ff    <= hdr_low_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         row_ff        <= row_in;
         column_ff     <= column_in;
         run_ff        <= run_in;
         line_left_ff  <= line_left_in;
         line_valid_ff <= line_valid_in;
         bytes_left_ff <= bytes_left_in;
         active_ff     <= active_in;
      end
   end

   // column and row of the drawn pixel are the values before the advance
   always_comb begin
      pix_req.emit  = emit;
      pix_req.index = data_b;
      pix_req.x     = column_ff[14:0];
      pix_req.y     = row_ff[14:0];
      if (run_ff == RUN_SKIP || run_ff == RUN_DRAW || first) begin
         pix_req.x = column_ff[14:0];
      end
   end

   always_comb begin
      pal_wr.write = accept && op == OP_PALETTE;
      pal_wr.index = req_tdata[39:32];
      pal_wr.color = {req_tdata[47:40], req_tdata[55:48], req_tdata[63:56]};
   end

   rle8sd_pixel_pipe #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_pixel_pipe (
      .clock      (clock),
      .reset      (reset),
      .pal_wr     (pal_wr),
      .pix_req    (pix_req),
      .in_ready   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTH
   a_hdr_bounded : assert property (@(posedge clock) disable iff (reset)
      hdr_count_ff <= HEADER_BYTES)
      else $error("header count past header length");

   a_active_bytes : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> bytes_left_ff != 24'd0)
      else $error("picture active with no bytes left");

   a_line_after_hdr : assert property (@(posedge clock) disable iff (reset)
      line_valid_ff |-> hdr_count_ff == HEADER_BYTES && line_left_ff != 8'd0)
      else $error("line open before header done or with no bytes");

   a_emit_in_width : assert property (@(posedge clock) disable iff (reset)
      emit |-> active_ff && line_valid_ff && column_ff < {1'b0, width_ff})
      else $error("pixel emitted outside an open line");
`endif

endmodule

// ===== bench/rle8_pixel_check.sv =====
`timescale 1ns / 1ps

module rle8_pixel_check #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   output int          fail_count,
   output int          pixels_pending
);
   import rle8sd_pkg::*;

   typedef struct packed {
      logic [14:0] x;
      logic [14:0] y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } pixel_type;

   // mirror of the decoder
   logic [23:0] pal [0:255];
   logic [3:0]  hdr_cnt;
   logic [7:0]  hdr_lo;
   logic [15:0] img_w;
   logic [15:0] img_h;
   logic [15:0] cur_row;
   logic [16:0] cur_col;
   logic [8:0]  run;
   logic [7:0]  line_left;
   logic        line_open;
   logic [23:0] left;
   logic        busy;

   pixel_type pixel_q [$];

   task automatic close_row();
      line_open = 1'b0;
      cur_row   = cur_row + 16'd1;
      if (cur_row >= img_h)
         busy = 1'b0;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic first,
                              input logic [23:0] fbytes,
                              output logic hit, output pixel_type pix);
      hit = 1'b0;
      pix = '0;
      if (first) begin
         busy      = (fbytes >= MIN_FRAME_BYTES);
         left      = fbytes;
         hdr_cnt   = '0;
         hdr_lo    = '0;
         cur_row   = '0;
         cur_col   = '0;
         run       = RUN_SKIP;
         line_left = '0;
         line_open = 1'b0;
      end
      if (!busy || left == 24'd0) begin
         busy = 1'b0;
         return;
      end
      left = left - 24'd1;

      if (hdr_cnt < HEADER_BYTES) begin
         case (hdr_cnt)
            HDR_WIDTH_LO, HDR_HEIGHT_LO: hdr_lo = b;
            HDR_WIDTH_HI:  img_w = {b, hdr_lo};
            HDR_HEIGHT_HI: img_h = {b, hdr_lo};
            default: ;
         endcase
         hdr_cnt = hdr_cnt + 4'd1;
         if (hdr_cnt == HEADER_BYTES) begin
            if (img_w == 16'd0 || img_w[15] || img_h == 16'd0 || img_h[15])
               busy = 1'b0;
            cur_row   = '0;
            line_open = 1'b0;
         end
      end else if (!line_open) begin
         if (b == 8'd0) begin
            close_row();
         end else if (left < 24'(b)) begin
            busy = 1'b0;
         end else begin
            line_open = 1'b1;
            line_left = b;
            run       = RUN_SKIP;
            cur_col   = '0;
         end
      end else begin
         if (run == RUN_SKIP) begin
            cur_col = cur_col + 17'(b);
            run     = RUN_DRAW;
         end else if (run == RUN_DRAW) begin
            run = RUN_SKIP + 9'(b);
         end else begin
            if (cur_col < {1'b0, img_w}) begin
               hit   = 1'b1;
               pix.x = cur_col[14:0];
               pix.y = cur_row[14:0];
               if (int'(b) < PALETTE_ENTRIES)
                  {pix.red, pix.green, pix.blue} = pal[b];
            end
            cur_col = cur_col + 17'd1;
            run     = run - 9'd1;
         end
         line_left = line_left - 8'd1;
         if (line_left == 8'd0)
            close_row();
      end

      if (left == 24'd0)
         busy = 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v, inout logic bad);
      if (want_v !== got_v) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
         bad = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      logic      hit;
      logic      bad;
      pixel_type pix;
      pixel_type want;
      if (reset) begin
         for (int i = 0; i < 256; i++)
            pal[i] = '0;
         hdr_cnt   = '0;
         hdr_lo    = '0;
         img_w     = '0;
         img_h     = '0;
         cur_row   = '0;
         cur_col   = '0;
         run       = RUN_SKIP;
         line_left = '0;
         line_open = 1'b0;
         left      = '0;
         busy      = 1'b0;
         pixel_q.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == OP_PALETTE) begin
               if (int'(req_tdata[39:32]) < PALETTE_ENTRIES)
                  pal[req_tdata[39:32]] = {req_tdata[47:40], req_tdata[55:48],
                                           req_tdata[63:56]};
            end else begin
               decode_byte(req_tdata[7:0], req_tuser[1], req_tdata[31:8], hit, pix);
               if (hit)
                  pixel_q.push_back(pix);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_q.size() == 0) begin
               $display("%0t: pixel x=%0d y=%0d arrived, expected none", $time,
                        rsp_tdata[14:0], rsp_tdata[29:15]);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_q.pop_front();
               bad  = 1'b0;
               check_field("pixel_x", 32'(want.x), 32'(rsp_tdata[14:0]), bad);
               check_field("pixel_y", 32'(want.y), 32'(rsp_tdata[29:15]), bad);
               check_field("red_out", 32'(want.red), 32'(rsp_tdata[37:30]), bad);
               check_field("green_out", 32'(want.green), 32'(rsp_tdata[45:38]), bad);
               check_field("blue_out", 32'(want.blue), 32'(rsp_tdata[53:46]), bad);
               check_field("pad", 32'd0, 32'(rsp_tdata[55:54]), bad);
               if (bad)
                  fail_count <= fail_count + 1;
            end
         end
      end
      pixels_pending <= pixel_q.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import rle8sd_pkg::*;

   typedef enum {SPRITE_CLEAN, SPRITE_FLAWED, SPRITE_DENSE} sprite_style_type;

   localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the pipeline
   localparam int PHASE_ITEMS = 110;   // random transfers per idling phase

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // data_byte[7:0], frame_bytes[31:8], palette_index[39:32],
   // red_in[47:40], green_in[55:48], blue_in[63:56]
   logic [63:0] req_tdata  = '0;
   // op[0], first_byte[1]
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // pixel_x[14:0], pixel_y[29:15], red_out[37:30], green_out[45:38],
   // blue_out[53:46], zero pad[55:54]
   logic [55:0] rsp_tdata;

   int fail_count;
   int pixels_pending;

   // idling odds in percent, set per phase by the stimulus
   int send_idle_pct = 6;
   int recv_idle_pct = 63;
   // hold-off requests from the stimulus, served by the receiver process
   int holds_wanted  = 0;
   int holds_done    = 0;
   int hold_left     = 0;
   int items_sent    = 0;

   rle8_sprite_decoder uut (.*);

   rle8_pixel_check check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up long after the slowest correct run could have finished.
   initial begin
      #3ms;
      $display("Verification failed");
      $finish;
   end

   // Receiver: random back-pressure, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_wanted) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one item and hold it until the transfer. An idle gap lowers valid
   // first; without a gap valid stays high into the next item.
   task automatic send_item(input logic op, input logic first, input logic [7:0] dbyte,
                            input logic [23:0] fbytes, input logic [7:0] pidx,
                            input logic [23:0] rgb);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], pidx, fbytes, dbyte};
      req_tuser  <= {first, op};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Picture byte: the unused palette fields carry noise, and so does the
   // frame size when the byte does not open a picture.
   task automatic send_byte(input logic first, input logic [7:0] b, input logic [23:0] fb);
      send_item(OP_PIXEL, first, b, first ? fb : 24'($urandom), 8'($urandom),
                24'($urandom));
   endtask

   // Palette write: the picture fields, first_byte included, carry noise.
   task automatic send_palette(input logic [7:0] idx, input logic [23:0] rgb);
      send_item(OP_PALETTE, 1'($urandom), 8'($urandom), 24'($urandom), idx, rgb);
   endtask

   // Send the first count bytes of a picture, now and then slipping in a
   // palette write between them.
   task automatic send_picture(input logic [7:0] pic[$], input logic [23:0] fb,
                               input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(29) == 0)
            send_palette(8'($urandom), 24'($urandom));
         send_byte(i == 0, pic[i], fb);
      end
   endtask

   // Build a sprite with random runs. Flawed sprites get one of: wrong line
   // lengths, a truncated frame size, a huge frame size cut short by the
   // next picture, or an overlong line.
   task automatic send_sprite(input sprite_style_type style);
      logic [7:0]  pic[$];
      logic [7:0]  line[$];
      logic [15:0] w;
      logic [15:0] h;
      logic [23:0] fb;
      int          rows;
      int          flaw;
      int          n;
      int          len;
      int          cut;
      w = 16'($urandom_range(1, 24));
      h = 16'($urandom_range(1, 5));
      if (style == SPRITE_DENSE) begin
         w = 16'd16;
         h = 16'd6;
      end else if ($urandom_range(9) == 0) begin
         case ($urandom_range(5))
            0: w = 16'd0;
            1: w = 16'h7FFF;
            2: w = 16'h8000 | 16'($urandom);
            3: h = 16'd0;
            4: h = 16'h8000 | 16'($urandom);
            default: w = 16'($urandom_range(256, 700));
         endcase
      end
      flaw = (style == SPRITE_FLAWED) ? $urandom_range(1, 4) : 0;
      pic = '{w[7:0], w[15:8], h[7:0], h[15:8],
              8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      rows = (h >= 16'd1 && h <= 16'd8) ? int'(h) : $urandom_range(0, 3);
      for (int r = 0; r < rows; r++) begin
         line.delete();
         if (style != SPRITE_DENSE && $urandom_range(7) == 0) begin
            pic.push_back(8'd0);
            continue;
         end
         repeat (style == SPRITE_DENSE ? 1 : $urandom_range(1, 3)) begin
            if (style == SPRITE_DENSE)
               line.push_back(8'd0);
            else if ($urandom_range(9) == 0)
               line.push_back(8'($urandom));
            else
               line.push_back(8'($urandom_range(0, 5)));
            n = (style == SPRITE_DENSE) ? 16 : $urandom_range(0, 7);
            line.push_back(8'(n));
            repeat (n) line.push_back(8'($urandom));
         end
         len = line.size();
         if (flaw == 1 && $urandom_range(2) == 0)
            len = $urandom_range(1, 40);
         if (flaw == 4 && r == rows / 2)
            len = 250;
         pic.push_back(8'(len));
         foreach (line[i])
            pic.push_back(line[i]);
      end
      fb  = 24'(pic.size());
      cut = pic.size();
      case (flaw)
         2: fb = 24'($urandom_range(1, pic.size()));
         3: begin
            fb  = 24'($urandom);
            cut = $urandom_range(1, pic.size());
         end
         default: ;
      endcase
      send_picture(pic, fb, cut);
   endtask

   // One idling setting: mostly sprites, the rest palette writes and noise.
   task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
      int goal;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      goal = items_sent + PHASE_ITEMS;
      if (with_hold) begin
         // hold the receiver off while a pixel-heavy sprite keeps arriving
         holds_wanted++;
         send_sprite(SPRITE_DENSE);
      end
      while (items_sent < goal) begin
         int pick;
         pick = $urandom_range(99);
         if (pick < 65)
            send_sprite(SPRITE_CLEAN);
         else if (pick < 80)
            send_sprite(SPRITE_FLAWED);
         else if (pick < 90)
            repeat ($urandom_range(1, 4)) send_palette(8'($urandom), 24'($urandom));
         else
            repeat ($urandom_range(1, 6))
               send_item(OP_PIXEL, ($urandom_range(3) == 0), 8'($urandom),
                         ($urandom_range(1) == 0) ? 24'($urandom_range(0, 9))
                                                  : 24'($urandom),
                         8'($urandom), 24'($urandom));
      end
   endtask

   initial begin
      int drain;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole palette so that no pixel can read an unwritten entry.
      for (int i = 0; i < 256; i++)
         send_palette(8'(i), (i == 0) ? 24'h000000 :
                             (i == 255) ? 24'hFFFFFF : 24'($urandom));

      // byte with no picture active: dropped
      send_byte(1'b0, 8'hA5, 24'd0);
      // zero-size and short pictures: bytes dropped
      send_picture('{8'h01}, 24'd0, 1);
      send_picture('{8'h01, 8'h00, 8'h01}, 24'd7, 3);
      // header cut off by a new picture
      send_picture('{8'h03, 8'h00, 8'h02}, 24'hFFFFFF, 3);
      // 2x2 sprite: palette extremes, a pixel beyond the width, an empty line
      send_picture('{8'h02, 8'h00, 8'h02, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h05, 8'h00, 8'h03, 8'hFF, 8'h00, 8'h07, 8'h00}, 24'd15, 15);
      // negative width ends the picture after the header
      send_picture('{8'h00, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h03}, 24'd9, 9);
      // line length beyond the bytes left ends the picture
      send_picture('{8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h09, 8'h00, 8'h01}, 24'd11, 11);

      run_phase(6, 63, 1'b0);
      run_phase(63, 6, 1'b0);
      run_phase(0, 0, 1'b1);
      req_tvalid <= 1'b0;

      // Drain outstanding pixels, then allow for the output latency.
      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (pixels_pending != 0 && drain < 20000);
      repeat (20) @(posedge clock);

      if (pixels_pending != 0)
         $display("%0t: %0d pixels never arrived", $time, pixels_pending);
      if (fail_count == 0 && pixels_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
